### hdl/bba_pkg.sv
// Package for the bitmap block allocator: field widths, default sizes,
// operation and status codes shared by the interfaces and the core.
// No dependencies.
package bba_pkg;

    // Default sizing (WORD_BITS is a power of two)
    localparam int MAX_BLOCKS_DEF = 2048;
    localparam int WORD_BITS_DEF  = 64;

    // Fixed field widths
    localparam int FUNC_W   = 2;
    localparam int INDEX_W  = 11;
    localparam int COUNT_W  = 12;
    localparam int STATUS_W = 3;

    // Block count after reset
    localparam logic [COUNT_W-1:0] NUM_BLOCKS_RST = 12'd2048;

    // Request operation codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_ALLOC = 2'd0,
        FUNC_FREE  = 2'd1,
        FUNC_CHECK = 2'd2
    } func_t;

    // Response status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_NO_FREE      = 3'd1,
        ST_BAD_INDEX    = 3'd2,
        ST_ALREADY_FREE = 3'd3,
        ST_MISMATCH     = 3'd4
    } status_t;

endpackage

### hdl/bba_req_if.sv
// Request channel of the bitmap block allocator: valid/ready plus payload.
// Depends on bba_pkg.
interface bba_req_if;
    import bba_pkg::*;

    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [INDEX_W-1:0] block_index;

    modport source (output valid, output func, output block_index, input ready);
    modport sink   (input valid, input func, input block_index, output ready);
endinterface

### hdl/bba_rsp_if.sv
// Response channel of the bitmap block allocator: valid/ready plus payload.
// Depends on bba_pkg.
interface bba_rsp_if;
    import bba_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  result_index;
    logic [COUNT_W-1:0]  used_blocks;
    logic [COUNT_W-1:0]  free_blocks;

    modport source (output valid, output status, output result_index,
                    output used_blocks, output free_blocks, input ready);
    modport sink   (input valid, input status, input result_index,
                    input used_blocks, input free_blocks, output ready);
endinterface

### hdl/bba_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hdl/bitmap_block_allocator_core.sv
// First-fit bitmap block allocator core.
// Depends on bba_pkg, bba_req_if, bba_rsp_if and bba_ram.
//
// Usage:
//   req carries one request beat (func, block_index); rsp returns exactly one
//   response beat per request (status, result_index, used_blocks, free_blocks).
//   cfg_we/cfg_wdata write num_blocks; write it only while no request is open.
//   The used-block bitmap sits in a RAM of NUM_WORDS words of WORD_BITS bits,
//   read one word per cycle through its single read port.
// Work per request, from accept to response valid:
//   allocate: scans from word 0, at most NUM_WORDS words; no scan if full
//   free: reads the indexed word; no read for an out-of-range index
//   check: reads all NUM_WORDS words (32 with the defaults)
// A new request is taken in the cycle after the response is loaded, so
// requests are served one at a time and a check holds off the next one.
// Reset: bitmap reads as all free through per-word valid flags (no clearing
//   pass), used count zero, num_blocks 2048.
// Stall: a waiting response sits in the output register; the next request is
//   still accepted and worked on, and its response waits until the slot frees.
module bitmap_block_allocator_core #(
    parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF,
    parameter int WORD_BITS  = bba_pkg::WORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [bba_pkg::COUNT_W-1:0]  cfg_wdata,
    bba_req_if.sink                      req,
    bba_rsp_if.source                    rsp
);
    import bba_pkg::*;

    localparam int NUM_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int WA_W      = NUM_WORDS > 1 ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int SPAN      = NUM_WORDS * WORD_BITS;
    localparam int POP_W     = $clog2(SPAN + 1);
    localparam int LIM_W     = POP_W > COUNT_W ? POP_W : COUNT_W;
    localparam int PC_W      = $clog2(WORD_BITS + 1);
    localparam logic [WA_W-1:0] LAST_WORD = WA_W'(NUM_WORDS - 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_FREE  = 5'b00100,
        S_CHECK = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    // Control state
    state_t               state_reg, state_next;
    logic                 out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0]   used_count_reg, used_count_next;
    logic [COUNT_W-1:0]   num_blocks_reg;
    logic [NUM_WORDS-1:0] word_valid_reg;
    logic                 rd_valid_reg;

    // Working payload
    logic [WA_W-1:0]      w_reg, w_next;
    logic [INDEX_W-1:0]   idx_reg, idx_next;
    logic [POP_W-1:0]     pop_reg, pop_next;
    status_t              status_reg, status_next;
    logic [INDEX_W-1:0]   res_reg, res_next;
    logic                 wr_pend_reg, wr_pend_next;
    logic [WORD_BITS-1:0] wdata_reg, wdata_next;
    logic                 inc_reg, inc_next;
    logic                 dec_reg, dec_next;

    // Output register
    status_t              out_status_reg, out_status_next;
    logic [INDEX_W-1:0]   out_index_reg, out_index_next;
    logic [COUNT_W-1:0]   out_used_reg, out_used_next;
    logic [COUNT_W-1:0]   out_free_reg, out_free_next;

    // RAM access
    logic                 rd_en;
    logic [WA_W-1:0]      rd_addr;
    logic                 ram_we;
    logic [WORD_BITS-1:0] ram_rdata;
    logic [WORD_BITS-1:0] word;

    // Datapath helpers
    logic [LIM_W-1:0]     lim;
    logic [LIM_W-1:0]     base;
    logic [LIM_W-1:0]     base_step;
    logic [LIM_W-1:0]     cand;
    logic [BIT_W-1:0]     zero_pos;
    logic                 any_zero;
    logic                 last_scan;
    logic [PC_W-1:0]      word_pop;
    logic [POP_W-1:0]     pop_sum;
    logic [COUNT_W-1:0]   cnt_new;
    logic [COUNT_W-1:0]   free_new;
    logic                 out_free;
    logic [BIT_W-1:0]     idx_bit;
    logic [WA_W-1:0]      req_word;

    bba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (w_reg),
        .wdata (wdata_reg),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Words never written read as all free
    assign word = rd_valid_reg ? ram_rdata : '0;

    // Effective block limit for scan and index test
    always_comb
    begin
        if (LIM_W'(num_blocks_reg) > LIM_W'(MAX_BLOCKS))
        begin
            lim = LIM_W'(MAX_BLOCKS);
        end
        else
        begin
            lim = LIM_W'(num_blocks_reg);
        end
    end

    // Locate the lowest free bit of the current word
    always_comb
    begin
        zero_pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!word[i])
            begin
                zero_pos = BIT_W'(i);
            end
        end
    end

    assign any_zero  = ~&word;
    assign base      = LIM_W'({w_reg, {BIT_W{1'b0}}});
    assign base_step = base + LIM_W'(WORD_BITS);
    assign cand      = base + LIM_W'(zero_pos);
    assign last_scan = (w_reg == LAST_WORD) || (base_step >= lim);

    // Population count of the current word
    always_comb
    begin
        word_pop = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            word_pop = word_pop + PC_W'(word[i]);
        end
    end

    assign pop_sum  = pop_reg + POP_W'(word_pop);
    assign idx_bit  = idx_reg[BIT_W-1:0];
    assign req_word = WA_W'(req.block_index >> BIT_W);

    // Saturating count update and derived free count
    always_comb
    begin
        cnt_new = used_count_reg;
        if (inc_reg && used_count_reg != '1)
        begin
            cnt_new = used_count_reg + 1'b1;
        end
        else if (dec_reg && used_count_reg != '0)
        begin
            cnt_new = used_count_reg - 1'b1;
        end
        free_new = (cnt_new >= num_blocks_reg) ? '0 : num_blocks_reg - cnt_new;
    end

    assign out_free  = ~out_valid_reg | rsp.ready;
    assign req.ready = (state_reg == S_IDLE);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg & ~rsp.ready;
        used_count_next = used_count_reg;
        w_next          = w_reg;
        idx_next        = idx_reg;
        pop_next        = pop_reg;
        status_next     = status_reg;
        res_next        = res_reg;
        wr_pend_next    = wr_pend_reg;
        wdata_next      = wdata_reg;
        inc_next        = inc_reg;
        dec_next        = dec_reg;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        out_used_next   = out_used_reg;
        out_free_next   = out_free_reg;
        rd_en           = 1'b0;
        rd_addr         = w_reg;
        ram_we          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    idx_next     = req.block_index;
                    status_next  = ST_OK;
                    res_next     = '0;
                    wr_pend_next = 1'b0;
                    inc_next     = 1'b0;
                    dec_next     = 1'b0;
                    pop_next     = '0;
                    case (func_t'(req.func))
                        FUNC_ALLOC:
                        begin
                            if (used_count_reg < num_blocks_reg)
                            begin
                                w_next     = '0;
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                state_next = S_SCAN;
                            end
                            else
                            begin
                                status_next = ST_NO_FREE;
                                state_next  = S_DONE;
                            end
                        end
                        FUNC_FREE:
                        begin
                            if (LIM_W'(req.block_index) >= lim)
                            begin
                                status_next = ST_BAD_INDEX;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                w_next     = req_word;
                                rd_en      = 1'b1;
                                rd_addr    = req_word;
                                state_next = S_FREE;
                            end
                        end
                        FUNC_CHECK:
                        begin
                            w_next     = '0;
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            state_next = S_CHECK;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // Scan one word a cycle for the first free block
            S_SCAN:
            begin
                if (any_zero && cand < lim)
                begin
                    res_next     = INDEX_W'(cand);
                    wdata_next   = word | (WORD_BITS'(1) << zero_pos);
                    wr_pend_next = 1'b1;
                    inc_next     = 1'b1;
                    state_next   = S_DONE;
                end
                else if (any_zero || last_scan)
                begin
                    status_next = ST_NO_FREE;
                    state_next  = S_DONE;
                end
                else
                begin
                    w_next  = w_reg + 1'b1;
                    rd_en   = 1'b1;
                    rd_addr = w_reg + 1'b1;
                end
            end

            // Test and clear the addressed bit
            S_FREE:
            begin
                if (!word[idx_bit])
                begin
                    status_next = ST_ALREADY_FREE;
                end
                else
                begin
                    wdata_next   = word & ~(WORD_BITS'(1) << idx_bit);
                    wr_pend_next = 1'b1;
                    dec_next     = 1'b1;
                    res_next     = idx_reg;
                end
                state_next = S_DONE;
            end

            // Accumulate the bitmap population over all words
            S_CHECK:
            begin
                pop_next = pop_sum;
                if (w_reg == LAST_WORD)
                begin
                    if (used_count_reg > num_blocks_reg
                        || LIM_W'(pop_sum) != LIM_W'(used_count_reg))
                    begin
                        status_next = ST_MISMATCH;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    w_next  = w_reg + 1'b1;
                    rd_en   = 1'b1;
                    rd_addr = w_reg + 1'b1;
                end
            end

            // Commit the word and count, load the response beat
            S_DONE:
            begin
                if (out_free)
                begin
                    ram_we          = wr_pend_reg;
                    used_count_next = cnt_new;
                    out_status_next = status_reg;
                    out_index_next  = res_reg;
                    out_used_next   = cnt_new;
                    out_free_next   = free_new;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            used_count_reg <= '0;
            num_blocks_reg <= NUM_BLOCKS_RST;
            word_valid_reg <= '0;
            rd_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            used_count_reg <= used_count_next;
            if (cfg_we)
            begin
                num_blocks_reg <= cfg_wdata;
            end
            if (ram_we)
            begin
                word_valid_reg[w_reg] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= word_valid_reg[rd_addr];
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        w_reg          <= w_next;
        idx_reg        <= idx_next;
        pop_reg        <= pop_next;
        status_reg     <= status_next;
        res_reg        <= res_next;
        wr_pend_reg    <= wr_pend_next;
        wdata_reg      <= wdata_next;
        inc_reg        <= inc_next;
        dec_reg        <= dec_next;
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
        out_used_reg   <= out_used_next;
        out_free_reg   <= out_free_next;
    end

    // Drive the response channel
    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.result_index = out_index_reg;
    assign rsp.used_blocks  = out_used_reg;
    assign rsp.free_blocks  = out_free_reg;

endmodule
